### src/tli_pkg.sv
package tli_pkg;

  // Request kinds.
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // One stored point.
  typedef struct packed {
    logic signed [31:0] alt;
    logic signed [31:0] dens;
    logic signed [31:0] press;
  } point_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic   clear;
    logic   insert;
    logic   scan;
    point_t pt;
  } cell_ctl_t;

endpackage

### src/table_linear_interpolator_unit.sv
// Channel  Direction  Handshake       Fields
// in       input      valid / stall   kind, altitude, density_in, pressure_in
// out      output     valid / stall   density_out, pressure_out, status
//
// Clear, insert and an unused kind pass from S_WRITE straight to S_OUT. A
// query rotates the whole row once while the valid points pass the head cell,
// then goes to S_ADD when it clamps, or through the 48-step divider and the
// multiply to S_ADD when it interpolates. Reset is synchronous and empties
// the table. The result waits in an output register while out_stall is high.
module table_linear_interpolator_unit #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic signed [31:0] altitude,
  input  logic signed [31:0] density_in,
  input  logic signed [31:0] pressure_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] density_out,
  output logic signed [31:0] pressure_out,
  output logic [1:0]         status
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_SCAN, S_ROTATE, S_DIV_GO, S_DIV_WAIT, S_MUL, S_ADD, S_OUT
  } state_t;

  state_t                  state;
  tli_pkg::cell_ctl_t      ctl;
  tli_pkg::point_t         cell_pt    [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]  cell_valid;
  logic [TABLE_DEPTH-1:0]  cell_goes;
  logic [CW-1:0]           count;
  logic [CW-1:0]           turns;
  logic [1:0]              req_kind;
  logic signed [31:0]      req_alt;
  tli_pkg::point_t         prev;
  logic                    have_prev;
  logic                    found;
  tli_pkg::point_t         lo_pt;
  tli_pkg::point_t         hi_pt;
  logic                    div_start;
  logic                    div_done;
  logic [16:0]             ratio;
  logic [47:0]             div_num;
  logic [31:0]             div_den;
  logic signed [32:0]      d_dens;
  logic signed [32:0]      d_press;
  logic signed [50:0]      p_dens;
  logic signed [50:0]      p_press;
  logic signed [32:0]      head_gap;

  // Row of cells, head at index zero.
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    tli_pkg::point_t lp;
    tli_pkg::point_t rp;
    logic lv, lg, rv;
    if (g == 0) begin : g_head
      // The head's left edge counts as occupied so a new point may land there.
      assign lp = ctl.pt;
      assign lv = 1'b1;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lp = cell_pt[g-1];
      assign lv = cell_valid[g-1];
      assign lg = cell_goes[g-1];
    end
    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign rp = cell_pt[0];
      assign rv = cell_valid[0];
    end else begin : g_body
      assign rp = cell_pt[g+1];
      assign rv = cell_valid[g+1];
    end
    tli_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .left_pt    (lp),
      .left_valid (lv),
      .left_goes  (lg),
      .right_pt   (rp),
      .right_valid(rv),
      .pt         (cell_pt[g]),
      .valid      (cell_valid[g]),
      .goes       (cell_goes[g])
    );
  end

  // Cell controls decoded from state.
  always_comb begin
    ctl        = '0;
    ctl.pt.alt   = req_alt;
    ctl.pt.dens  = density_out;
    ctl.pt.press = pressure_out;
    ctl.clear  = (state == S_WRITE) && (req_kind == tli_pkg::KIND_CLEAR);
    ctl.insert = (state == S_WRITE) && (req_kind == tli_pkg::KIND_INSERT)
                 && (count < CW'(TABLE_DEPTH));
    ctl.scan   = (state == S_SCAN) ||
                 ((state == S_ROTATE) && (turns != CW'(TABLE_DEPTH)));
  end

  assign head_gap = 33'(req_alt) - 33'(lo_pt.alt);
  assign div_num  = {head_gap[31:0], 16'd0};
  assign div_den  = 32'(33'(hi_pt.alt) - 33'(lo_pt.alt));
  assign div_start = (state == S_DIV_GO);

  tli_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (ratio)
  );

  assign in_stall = (state != S_IDLE);

  // Sequencer and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_kind     <= kind;
            req_alt      <= altitude;
            density_out  <= density_in;
            pressure_out <= pressure_in;
            state        <= S_WRITE;
          end
        end
        S_WRITE: begin
          status <= tli_pkg::STATUS_OK;
          turns  <= '0;
          have_prev <= 1'b0;
          found  <= 1'b0;
          state  <= S_OUT;
          if (req_kind == tli_pkg::KIND_CLEAR) begin
            count <= '0;
          end else if (req_kind == tli_pkg::KIND_INSERT) begin
            if (count < CW'(TABLE_DEPTH)) begin
              count <= count + CW'(1);
            end else begin
              status <= tli_pkg::STATUS_FULL;
            end
          end else if (req_kind == tli_pkg::KIND_QUERY) begin
            if (count == '0) begin
              status <= tli_pkg::STATUS_EMPTY;
            end else begin
              state <= S_SCAN;
            end
          end
          if (req_kind != tli_pkg::KIND_QUERY || count == '0) begin
            density_out  <= '0;
            pressure_out <= '0;
          end
        end
        S_SCAN: begin
          // Head cell shows point number "turns" before this edge's rotation.
          // Every valid point is seen; a query at or above the last point
          // clamps to it, unless it already clamped to the first point.
          turns <= turns + CW'(1);
          prev  <= cell_pt[0];
          have_prev <= 1'b1;
          if (turns == count - CW'(1)) begin
            state <= S_ROTATE;
          end
          if (turns == count - CW'(1) && req_alt >= cell_pt[0].alt
              && !(found && lo_pt.alt == hi_pt.alt)) begin
            lo_pt <= cell_pt[0];
            hi_pt <= cell_pt[0];
            found <= 1'b1;
          end else if (!found && !have_prev && req_alt <= cell_pt[0].alt) begin
            lo_pt <= cell_pt[0];
            hi_pt <= cell_pt[0];
            found <= 1'b1;
          end else if (!found && have_prev && req_alt <= cell_pt[0].alt) begin
            lo_pt <= prev;
            hi_pt <= cell_pt[0];
            found <= 1'b1;
          end
        end
        S_ROTATE: begin
          // Rotate until the row has made one full turn.
          if (turns == CW'(TABLE_DEPTH)) begin
            state <= (lo_pt.alt == hi_pt.alt) ? S_ADD : S_DIV_GO;
          end else begin
            turns <= turns + CW'(1);
          end
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          p_dens  <= 51'(d_dens * $signed({1'b0, ratio}));
          p_press <= 51'(d_press * $signed({1'b0, ratio}));
          state   <= S_ADD;
        end
        S_ADD: begin
          if (lo_pt.alt == hi_pt.alt) begin
            density_out  <= lo_pt.dens;
            pressure_out <= lo_pt.press;
          end else begin
            density_out  <= 32'(51'(lo_pt.dens) + (p_dens >>> 16));
            pressure_out <= 32'(51'(lo_pt.press) + (p_press >>> 16));
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign d_dens  = 33'(hi_pt.dens) - 33'(lo_pt.dens);
  assign d_press = 33'(hi_pt.press) - 33'(lo_pt.press);

endmodule

### src/tli_cell.sv
// One table slot. On insert each cell compares its key with the new point and
// either keeps its point, takes the new one, or takes its left neighbor's
// point, so the points with greater keys all shift right by one together. During a scan
// the row rotates left by one slot a cycle so that the head cell presents
// consecutive points to the sequencer.
module tli_cell (
  input  logic              clk,
  input  logic              rst,
  input  tli_pkg::cell_ctl_t ctl,
  input  tli_pkg::point_t   left_pt,
  input  logic              left_valid,
  input  logic              left_goes,
  input  tli_pkg::point_t   right_pt,
  input  logic              right_valid,
  output tli_pkg::point_t   pt,
  output logic              valid,
  output logic              goes
);

  // A valid point with a key greater than the new one moves right.
  assign goes = valid && (pt.alt > ctl.pt.alt);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.insert) begin
      if (left_goes) begin
        pt    <= left_pt;
        valid <= left_valid;
      end else if (goes || !valid) begin
        // The new point lands in the first cell that moves or is free, right
        // after an occupied neighbor (the head's left edge counts as occupied).
        if (left_valid) begin
          pt    <= ctl.pt;
          valid <= 1'b1;
        end
      end
    end else if (ctl.scan) begin
      pt    <= right_pt;
      valid <= right_valid;
    end
  end

endmodule

### src/tli_divider.sv
// Restoring divider: 48-bit dividend over a 32-bit divisor, one quotient bit
// per cycle. Only the low 17 quotient bits are ever nonzero, so 48 steps
// keep the full width but the remainder stays 33 bits.
module tli_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [16:0] quot
);

  logic [47:0] dvd;
  logic [32:0] rem;
  logic [5:0]  step;
  logic        busy;
  logic [32:0] rem_sh;
  logic [33:0] diff;

  assign rem_sh = {rem[31:0], dvd[47]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        dvd  <= num;
        rem  <= '0;
        step <= '0;
      end else if (busy) begin
        if (diff[33]) begin
          rem <= rem_sh;
          dvd <= {dvd[46:0], 1'b0};
        end else begin
          rem <= diff[32:0];
          dvd <= {dvd[46:0], 1'b1};
        end
        step <= step + 6'd1;
        if (step == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = dvd[16:0];

endmodule

### src/tli_checker.sv
module tli_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [1:0]        kind,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [31:0] density_out,
  input logic signed [31:0] pressure_out,
  input logic [1:0]        status
);

  // A waiting result holds its density and status.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(density_out) && $stable(status))
    else $error("result changed while stalled");

  // One request at a time: no input taken while a result waits.
  a_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request taken while result pending");

  // An accepted clear answers ok with zero values.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && kind == tli_pkg::KIND_CLEAR |=> ##2
    out_valid && status == tli_pkg::STATUS_OK && density_out == 0 && pressure_out == 0)
    else $error("clear result wrong");

  // Errors carry zero values.
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != tli_pkg::STATUS_OK |-> density_out == 0 && pressure_out == 0)
    else $error("error result carries data");

endmodule

bind table_linear_interpolator_unit tli_checker u_tli_checker (.*);
